@@ src/frdf_pkg.sv @@
// shared types and constants of the flooding relay duplicate filter
package frdf_pkg;

	localparam int unsigned ID_RING_DEPTH_DEF = 16;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned IN_TDATA_W = 48;
	localparam int unsigned OUT_TDATA_W = 88;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = 1;
	localparam int unsigned QUEUE_CNT_W = 2;
	localparam logic [7:0] HOP_STAMP_LIMIT = 8'd5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROLE    = 1'b0,
		REG_NODE_ID = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ROLE_MASTER       = 2'd0,
		ROLE_RECEIVER     = 2'd1,
		ROLE_REPEATER     = 2'd2,
		ROLE_RECV_REPEAT  = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		KIND_FROM_MASTER = 2'd0,
		KIND_TO_MASTER   = 2'd1,
		KIND_INTERNAL    = 2'd2,
		KIND_UNKNOWN     = 2'd3
	} msg_kind_t;

	typedef enum logic [1:0] {
		SUB_ECHO_REQ   = 2'd0,
		SUB_ECHO_REPLY = 2'd1
	} sub_kind_t;

	typedef enum logic {
		OP_RECEIVED = 1'b0,
		OP_SENT     = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE         = 3'd0,
		ACT_CLIENT_PARSE = 3'd1,
		ACT_MASTER_PARSE = 3'd2,
		ACT_ECHO_REPLY   = 3'd3,
		ACT_COUNT_REPLY  = 3'd4,
		ACT_BAD_SUBTYPE  = 3'd5,
		ACT_BAD_TYPE     = 3'd6,
		ACT_DROPPED      = 3'd7
	} action_t;

	// classified header as handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] msg_id;
		logic [7:0]  hop_count;
		logic        repeater;
		logic        stamp;
		logic        is_cmd;
		action_t     action;
	} job_t;

	// result item, lowest field last so that it lands in the low bits
	typedef struct packed {
		logic [31:0] commands_received;
		logic [31:0] message_count;
		action_t     action;
		logic [4:0]  stamp_offset;
		logic        stamp_valid;
		logic [7:0]  new_hop_count;
		logic        forward;
		logic        duplicate;
	} result_t;

endpackage

@@ src/flood_relay_dedup_filter.sv @@
// top level of the flooding relay duplicate filter
//
// s_axis takes one message header per item: tuser is the operation (received
// or locally sent), tdata carries id, hop count, kind and subkind. m_axis
// gives one result per item: duplicate flag, forward flag, new hop count,
// stamp valid and offset, dispatch action and both running counters.
// cfg_we/cfg_index/cfg_data write the role; a write to the node id index
// has no effect on any result field and is accepted without storage.
// the back sequencer works on one item at a time and takes the next header
// from the queue only after it has committed the result of the last one
// (queue pop, parallel ring compare, decide and commit)
// a two-entry queue sits between the front and the back, so the sender may
// keep pushing while the back works or waits on a stalled receiver; when
// m_axis_tready is low the result is held and the back stops in its decide
// step, after which the queue fills and s_axis_tready falls
// reset clears the id ring to zero, the ring index, both counters and role;
// the block takes items in the first cycle after reset
module flood_relay_dedup_filter #(
	parameter int unsigned ID_RING_DEPTH = frdf_pkg::ID_RING_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [frdf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [frdf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// msg_id[31:0], hop_count[39:32], msg_kind[41:40], sub_kind[43:42]
	input  logic [frdf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// duplicate[0], forward[1], new_hop_count[9:2], stamp_valid[10],
	// stamp_offset[15:11], action[18:16], message_count[50:19],
	// commands_received[82:51]
	output logic [frdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import frdf_pkg::*;

	logic [1:0] role_q;
	logic       push_valid;
	logic       push_ready;
	job_t       push_job;
	logic       pop_valid;
	logic       pop_ready;
	job_t       pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= ROLE_MASTER;
		end else if (cfg_we && (cfg_index == REG_ROLE)) begin
			role_q <= cfg_data[1:0];
		end
	end

	frdf_front u_front (
		.role          (role_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_job      (push_job)
	);

	frdf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_job    (push_job),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_job   (pop_job)
	);

	frdf_back #(
		.ID_RING_DEPTH (ID_RING_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (pop_valid),
		.job_ready     (pop_ready),
		.job           (pop_job),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	a_dup_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[18:16] == ACT_DROPPED)
			&& !m_axis_tdata[1] && !m_axis_tdata[10])
		else $error("duplicate item not reported as dropped");

	a_dropped_dup: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[18:16] == ACT_DROPPED) |-> m_axis_tdata[0])
		else $error("dropped action without duplicate flag");

	a_stamp_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[1]
			&& (m_axis_tdata[15:11] <= 5'd16) && (m_axis_tdata[12:11] == 2'b00))
		else $error("stamp on an item that is not forwarded or bad offset");

endmodule

@@ src/frdf_front.sv @@
// front part: unpacks an incoming header and classifies it for the back part
module frdf_front (
	input  logic [1:0]                      role,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [frdf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                            s_axis_tuser,
	output logic                            push_valid,
	input  logic                            push_ready,
	output frdf_pkg::job_t                  push_job
);
	import frdf_pkg::*;

	logic [7:0] hops;
	logic [7:0] hops_inc;
	logic [1:0] kind;
	logic [1:0] sub;
	logic       is_master;
	logic       repeater;
	action_t    act;

	assign hops      = s_axis_tdata[39:32];
	assign kind      = s_axis_tdata[41:40];
	assign sub       = s_axis_tdata[43:42];
	assign hops_inc  = hops + 8'd1;
	assign is_master = (role == ROLE_MASTER);
	assign repeater  = (role == ROLE_REPEATER) || (role == ROLE_RECV_REPEAT);

	always_comb begin
		unique case (kind)
			KIND_FROM_MASTER: act = is_master ? ACT_NONE : ACT_CLIENT_PARSE;
			KIND_TO_MASTER:   act = is_master ? ACT_MASTER_PARSE : ACT_NONE;
			KIND_INTERNAL: begin
				if (sub == SUB_ECHO_REQ) begin
					act = ACT_ECHO_REPLY;
				end else if (sub == SUB_ECHO_REPLY) begin
					act = is_master ? ACT_COUNT_REPLY : ACT_NONE;
				end else begin
					act = ACT_BAD_SUBTYPE;
				end
			end
			default:          act = ACT_BAD_TYPE;
		endcase
	end

	always_comb begin
		push_job.op        = op_t'(s_axis_tuser);
		push_job.msg_id    = s_axis_tdata[31:0];
		push_job.hop_count = hops;
		push_job.repeater  = repeater;
		push_job.stamp     = repeater && (kind == KIND_INTERNAL) && (sub == SUB_ECHO_REPLY)
			&& (hops_inc < HOP_STAMP_LIMIT);
		push_job.is_cmd    = (kind == KIND_FROM_MASTER);
		push_job.action    = act;
	end

	assign push_valid    = s_axis_tvalid;
	assign s_axis_tready = push_ready;

endmodule

@@ src/frdf_queue.sv @@
// two-entry queue of classified headers between front and back
module frdf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  frdf_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_ready,
	output frdf_pkg::job_t out_job
);
	import frdf_pkg::*;

	job_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign in_ready  = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_job   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

@@ src/frdf_back.sv @@
// back part: id ring search and update, counters and result register
module frdf_back #(
	parameter int unsigned ID_RING_DEPTH = frdf_pkg::ID_RING_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  frdf_pkg::job_t                   job,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [frdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import frdf_pkg::*;

	localparam int unsigned IDX_W = $clog2(ID_RING_DEPTH);
	localparam int unsigned PAD_W = OUT_TDATA_W - $bits(result_t);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_MATCH  = 3'b010,
		ST_DECIDE = 3'b100
	} back_state_t;

	back_state_t              state_q;
	job_t                     job_q;
	logic [31:0]              ring_q [ID_RING_DEPTH];
	logic [ID_RING_DEPTH-1:0] hit_q;
	logic [IDX_W-1:0]         wr_idx_q;
	logic [31:0]              msg_cnt_q;
	logic [31:0]              cmd_cnt_q;
	result_t                  out_q;
	logic                     out_valid_q;

	logic                     hit;
	logic                     out_free;
	logic                     commit;
	logic                     record;
	logic [31:0]              msg_cnt_d;
	logic [31:0]              cmd_cnt_d;
	result_t                  res;

	assign hit       = |hit_q;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign commit    = (state_q == ST_DECIDE) && out_free;
	assign job_ready = (state_q == ST_IDLE);
	assign record    = (job_q.op == OP_SENT) || !hit;

	always_comb begin
		res           = '0;
		res.new_hop_count = job_q.hop_count;
		msg_cnt_d     = msg_cnt_q;
		cmd_cnt_d     = cmd_cnt_q;
		priority if (job_q.op == OP_SENT) begin
			msg_cnt_d = msg_cnt_q + 32'd1;
		end else if (hit) begin
			res.duplicate = 1'b1;
			res.action    = ACT_DROPPED;
		end else begin
			msg_cnt_d = msg_cnt_q + 32'd2;
			if (job_q.is_cmd) begin
				cmd_cnt_d = cmd_cnt_q + 32'd1;
			end
			res.action = job_q.action;
			if (job_q.repeater) begin
				res.forward       = 1'b1;
				res.new_hop_count = job_q.hop_count + 8'd1;
				if (job_q.stamp) begin
					res.stamp_valid  = 1'b1;
					res.stamp_offset = {res.new_hop_count[2:0], 2'b00};
				end
			end
		end
		res.message_count     = msg_cnt_d;
		res.commands_received = cmd_cnt_d;
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
		if (state_q == ST_MATCH) begin
			for (int k = 0; k < ID_RING_DEPTH; k++) begin
				hit_q[k] <= (ring_q[k] == job_q.msg_id);
			end
		end
		if (commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ID_RING_DEPTH; k++) begin
				ring_q[k] <= '0;
			end
			wr_idx_q <= '0;
		end else if (commit && record) begin
			ring_q[wr_idx_q] <= job_q.msg_id;
			if (wr_idx_q == IDX_W'(ID_RING_DEPTH - 1)) begin
				wr_idx_q <= '0;
			end else begin
				wr_idx_q <= wr_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			msg_cnt_q   <= '0;
			cmd_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				msg_cnt_q   <= msg_cnt_d;
				cmd_cnt_q   <= cmd_cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q};

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the flooding relay duplicate filter
module tb;
	import frdf_pkg::*;

	localparam int RING_DEPTH = ID_RING_DEPTH_DEF;
	localparam int ITEMS_PER_PHASE = 142;
	localparam int PHASES = 6;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int HISTORY_DEPTH = 32;
	localparam logic [1:0] SUB_UNKNOWN_A = 2'd2;
	localparam logic [1:0] SUB_UNKNOWN_B = 2'd3;

	typedef struct packed {
		op_t         op;
		logic [31:0] msg_id;
		logic [7:0]  hop_count;
		msg_kind_t   msg_kind;
		logic [1:0]  sub_kind;
	} header_t;

	typedef struct {
		role_t   role;
		header_t hdr;
		bit      typed;
		result_t res;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor state
	logic [31:0] id_ring [RING_DEPTH];
	int          ring_wr;
	logic [31:0] msg_total;
	logic [31:0] cmd_total;
	role_t       cur_role;

	result_t     expected_results [$];
	logic [31:0] recent_ids [$];
	stim_row_t   stim_table [$];
	int          bad_fields;
	int          burst_left;
	bit          long_hold_req;

	flood_relay_dedup_filter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic result_t predict_header(input header_t h);
		result_t r;
		logic    hit;
		logic    rep;
		r = '0;
		r.new_hop_count = h.hop_count;
		r.action = ACT_NONE;
		rep = (cur_role == ROLE_REPEATER) || (cur_role == ROLE_RECV_REPEAT);
		hit = 1'b0;
		foreach (id_ring[k])
			if (id_ring[k] == h.msg_id)
				hit = 1'b1;
		if (h.op == OP_SENT) begin
			id_ring[ring_wr] = h.msg_id;
			ring_wr = (ring_wr + 1) % RING_DEPTH;
			msg_total = msg_total + 32'd1;
		end else if (hit) begin
			r.duplicate = 1'b1;
			r.action = ACT_DROPPED;
		end else begin
			id_ring[ring_wr] = h.msg_id;
			ring_wr = (ring_wr + 1) % RING_DEPTH;
			msg_total = msg_total + 32'd2;
			if (rep) begin
				r.forward = 1'b1;
				r.new_hop_count = h.hop_count + 8'd1;
				if (h.msg_kind == KIND_INTERNAL && h.sub_kind == SUB_ECHO_REPLY &&
						r.new_hop_count < HOP_STAMP_LIMIT) begin
					r.stamp_valid = 1'b1;
					r.stamp_offset = {r.new_hop_count[2:0], 2'b00};
				end
			end
			case (h.msg_kind)
				KIND_FROM_MASTER: begin
					cmd_total = cmd_total + 32'd1;
					r.action = (cur_role == ROLE_MASTER) ? ACT_NONE : ACT_CLIENT_PARSE;
				end
				KIND_TO_MASTER: begin
					r.action = (cur_role == ROLE_MASTER) ? ACT_MASTER_PARSE : ACT_NONE;
				end
				KIND_INTERNAL: begin
					if (h.sub_kind == SUB_ECHO_REQ)
						r.action = ACT_ECHO_REPLY;
					else if (h.sub_kind == SUB_ECHO_REPLY)
						r.action = (cur_role == ROLE_MASTER) ? ACT_COUNT_REPLY : ACT_NONE;
					else
						r.action = ACT_BAD_SUBTYPE;
				end
				default: begin
					r.action = ACT_BAD_TYPE;
				end
			endcase
		end
		r.message_count = msg_total;
		r.commands_received = cmd_total;
		return r;
	endfunction

	function automatic result_t mk_result(input logic dup, input logic fwd,
			input logic [7:0] nhops, input logic sval, input logic [4:0] soff,
			input action_t act, input logic [31:0] msgs, input logic [31:0] cmds);
		result_t r;
		r.duplicate = dup;
		r.forward = fwd;
		r.new_hop_count = nhops;
		r.stamp_valid = sval;
		r.stamp_offset = soff;
		r.action = act;
		r.message_count = msgs;
		r.commands_received = cmds;
		return r;
	endfunction

	function automatic void add_row(input role_t role, input op_t op, input logic [31:0] id,
			input logic [7:0] hops, input msg_kind_t kind, input logic [1:0] sub,
			input bit typed, input result_t res);
		stim_row_t row;
		row.role = role;
		row.hdr.op = op;
		row.hdr.msg_id = id;
		row.hdr.hop_count = hops;
		row.hdr.msg_kind = kind;
		row.hdr.sub_kind = sub;
		row.typed = typed;
		row.res = res;
		stim_table = {stim_table, row};
	endfunction

	function automatic header_t random_header();
		header_t h;
		int      pick;
		h.op = ($urandom_range(0, 99) < 20) ? OP_SENT : OP_RECEIVED;
		pick = $urandom_range(0, 99);
		if (pick < 40 && recent_ids.size() != 0)
			h.msg_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		else if (pick < 50)
			h.msg_id = $urandom_range(0, 3);
		else
			h.msg_id = $urandom;
		if ($urandom_range(0, 99) < 35)
			h.hop_count = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 5) :
				$urandom_range(250, 255));
		else
			h.hop_count = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 40)
			h.msg_kind = KIND_INTERNAL;
		else
			h.msg_kind = msg_kind_t'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 40)
			h.sub_kind = SUB_ECHO_REPLY;
		else
			h.sub_kind = 2'($urandom_range(0, 3));
		return h;
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROLE)
			cur_role = role_t'(val[1:0]);
	endtask

	task automatic send_header(input header_t h, input bit typed, input result_t res);
		int      gap;
		result_t want;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, h.sub_kind, h.msg_kind, h.hop_count, h.msg_id};
		s_axis_tuser <= h.op;
		do @(posedge clk); while (!s_axis_tready);
		want = predict_header(h);
		expected_results = {expected_results, (typed ? res : want)};
		recent_ids = {recent_ids, h.msg_id};
		if (recent_ids.size() > HISTORY_DEPTH)
			void'(recent_ids.pop_front());
		burst_left--;
	endtask

	// sender pauses until every result is back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			bad_fields++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(result_t)-1:0];
			if (expected_results.size() == 0) begin
				$error("result item with nothing outstanding: %0h", m_axis_tdata);
				bad_fields++;
			end else begin
				want = expected_results.pop_front();
				check_field("duplicate", 32'(want.duplicate), 32'(got.duplicate));
				check_field("forward", 32'(want.forward), 32'(got.forward));
				check_field("new_hop_count", 32'(want.new_hop_count),
					32'(got.new_hop_count));
				check_field("stamp_valid", 32'(want.stamp_valid), 32'(got.stamp_valid));
				check_field("stamp_offset", 32'(want.stamp_offset),
					32'(got.stamp_offset));
				check_field("action", 32'(want.action), 32'(got.action));
				check_field("message_count", want.message_count, got.message_count);
				check_field("commands_received", want.commands_received,
					got.commands_received);
			end
		end
	end

	// receiver: random stall density per stretch, plus one long hold on request
	initial begin : sink_ready
		int stall_pct;
		int span;
		m_axis_tready = 1'b0;
		forever begin
			if (long_hold_req) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold_req = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		#(12 * 400000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		role_t       phase_role;
		logic [31:0] phase_node;
		header_t     h;
		cfg_we = 1'b0;
		cfg_index = REG_ROLE;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_RECEIVED;
		long_hold_req = 1'b0;
		burst_left = 0;
		bad_fields = 0;
		foreach (id_ring[k])
			id_ring[k] = '0;
		ring_wr = 0;
		msg_total = '0;
		cmd_total = '0;
		cur_role = ROLE_MASTER;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_ROLE, 32'(ROLE_MASTER));
		write_reg(REG_NODE_ID, 32'h0);

		// zero id hits the cleared ring
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h0, 8'd0, KIND_FROM_MASTER, SUB_ECHO_REQ, 1'b1,
			mk_result(1'b1, 1'b0, 8'd0, 1'b0, 5'd0, ACT_DROPPED, 32'd0, 32'd0));
		add_row(ROLE_MASTER, OP_RECEIVED, 32'hFFFF_FFFF, 8'd255, KIND_FROM_MASTER,
			SUB_ECHO_REQ, 1'b1,
			mk_result(1'b0, 1'b0, 8'd255, 1'b0, 5'd0, ACT_NONE, 32'd2, 32'd1));
		add_row(ROLE_MASTER, OP_RECEIVED, 32'hFFFF_FFFF, 8'd255, KIND_FROM_MASTER,
			SUB_ECHO_REQ, 1'b1,
			mk_result(1'b1, 1'b0, 8'd255, 1'b0, 5'd0, ACT_DROPPED, 32'd2, 32'd1));
		// sent id is recorded, then dropped when heard back
		add_row(ROLE_MASTER, OP_SENT, 32'h1234_5678, 8'd7, KIND_UNKNOWN, SUB_UNKNOWN_B, 1'b1,
			mk_result(1'b0, 1'b0, 8'd7, 1'b0, 5'd0, ACT_NONE, 32'd3, 32'd1));
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h1234_5678, 8'd1, KIND_TO_MASTER,
			SUB_ECHO_REQ, 1'b1,
			mk_result(1'b1, 1'b0, 8'd1, 1'b0, 5'd0, ACT_DROPPED, 32'd3, 32'd1));
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h1, 8'd3, KIND_TO_MASTER, SUB_ECHO_REQ, 1'b1,
			mk_result(1'b0, 1'b0, 8'd3, 1'b0, 5'd0, ACT_MASTER_PARSE, 32'd5, 32'd1));
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h2, 8'd0, KIND_INTERNAL, SUB_ECHO_REQ, 1'b0, '0);
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h3, 8'd2, KIND_INTERNAL, SUB_ECHO_REPLY, 1'b0,
			'0);
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h4, 8'd0, KIND_INTERNAL, SUB_UNKNOWN_A, 1'b0,
			'0);
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h5, 8'd0, KIND_INTERNAL, SUB_UNKNOWN_B, 1'b0,
			'0);
		add_row(ROLE_MASTER, OP_RECEIVED, 32'h6, 8'd9, KIND_UNKNOWN, SUB_ECHO_REQ, 1'b0, '0);
		// repeater roles and receiver: hop wrap, stamp offsets below and at the limit
		add_row(ROLE_RECV_REPEAT, OP_RECEIVED, 32'hA000_0001, 8'd255, KIND_INTERNAL,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_RECV_REPEAT, OP_RECEIVED, 32'hA000_0002, 8'd3, KIND_INTERNAL,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_RECV_REPEAT, OP_RECEIVED, 32'hA000_0003, 8'd4, KIND_INTERNAL,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_RECV_REPEAT, OP_RECEIVED, 32'h5555_AAAA, 8'hAA, KIND_FROM_MASTER,
			SUB_ECHO_REQ, 1'b0, '0);
		add_row(ROLE_RECV_REPEAT, OP_RECEIVED, 32'hAAAA_5555, 8'h55, KIND_TO_MASTER,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_RECV_REPEAT, OP_SENT, 32'hA000_0004, 8'd200, KIND_INTERNAL,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_RECEIVER, OP_RECEIVED, 32'hB000_0001, 8'd1, KIND_FROM_MASTER,
			SUB_ECHO_REQ, 1'b0, '0);
		add_row(ROLE_RECEIVER, OP_RECEIVED, 32'hB000_0002, 8'd0, KIND_INTERNAL,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_REPEATER, OP_RECEIVED, 32'hC000_0001, 8'd1, KIND_INTERNAL,
			SUB_ECHO_REPLY, 1'b0, '0);
		add_row(ROLE_REPEATER, OP_RECEIVED, 32'hC000_0002, 8'h55, KIND_INTERNAL,
			SUB_ECHO_REQ, 1'b0, '0);
		add_row(ROLE_REPEATER, OP_RECEIVED, 32'hC000_0003, 8'd0, KIND_UNKNOWN,
			SUB_UNKNOWN_B, 1'b0, '0);

		foreach (stim_table[i]) begin
			if (stim_table[i].role != cur_role) begin
				drain();
				write_reg(REG_ROLE, 32'(stim_table[i].role));
			end
			send_header(stim_table[i].hdr, stim_table[i].typed, stim_table[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: phase_role = ROLE_RECV_REPEAT;
				1: phase_role = ROLE_MASTER;
				2: phase_role = ROLE_REPEATER;
				3: phase_role = ROLE_RECEIVER;
				default: phase_role = role_t'($urandom_range(0, 3));
			endcase
			case (p)
				0: phase_node = 32'hFFFF_FFFF;
				1: phase_node = 32'h0;
				default: phase_node = $urandom;
			endcase
			write_reg(REG_NODE_ID, phase_node);
			write_reg(REG_ROLE, 32'(phase_role));
			if (p == 2) begin
				// receiver holds off while the sender keeps offering
				long_hold_req = 1'b1;
				burst_left = 120;
			end
			repeat (ITEMS_PER_PHASE) begin
				h = random_header();
				send_header(h, 1'b0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (bad_fields == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
